@@ rtl/imutc_pkg.sv @@
// Shared types, constants and the arctangent table for the tilt and motion block.
// No dependencies.
package imutc_pkg;

   localparam int WindowLenDefault = 5;
   localparam int CordicStepsDefault = 16;
   localparam int AtanTabLen = 24;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 24;

   // Register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_BLEND = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_WARMUP = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_STILL = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_TURN = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_SPIN = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_ACCEL = 3'd5;

   // Motion codes.
   localparam logic [2:0] MOTION_HALT = 3'd0;
   localparam logic [2:0] MOTION_ACCEL = 3'd1;
   localparam logic [2:0] MOTION_DECEL = 3'd2;
   localparam logic [2:0] MOTION_CONST = 3'd3;
   localparam logic [2:0] MOTION_LEFT = 3'd4;
   localparam logic [2:0] MOTION_RIGHT = 3'd5;
   localparam logic [2:0] MOTION_AROUND = 3'd6;

   localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
   localparam logic [31:0] GYRO_DIV = 32'd131000000;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic [19:0]        delta_time;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] roll_angle;
      logic signed [31:0] pitch_angle;
      logic signed [31:0] yaw_angle;
      logic [2:0]         motion_code;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_MAG, ST_SCALE, ST_ANG, ST_GYRO, ST_BLEND, ST_NEXT, ST_DONE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;      // capture input word, update warm-up and windows
      logic prep;      // seed first vectoring run for current axis
      logic mag_step;  // one vectoring step of magnitude run
      logic scale;     // multiply by inverse gain
      logic ang_step;  // one vectoring step of angle run
      logic gyro;      // one partial product of the gyro increment
      logic blend;     // blend and store current axis; yaw takes the gyro increment alone
      logic next_axis; // advance axis counter
      logic finish;    // update motion code and produce the word
   } cmd_type;

   typedef struct packed {
      logic step_last;
      logic div_last;
      logic axis_last;
   } sts_type;

   function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
      case (i)
         5'd0: atan_q16 = 32'sd2949120;
         5'd1: atan_q16 = 32'sd1740967;
         5'd2: atan_q16 = 32'sd919879;
         5'd3: atan_q16 = 32'sd466945;
         5'd4: atan_q16 = 32'sd234379;
         5'd5: atan_q16 = 32'sd117304;
         5'd6: atan_q16 = 32'sd58666;
         5'd7: atan_q16 = 32'sd29335;
         5'd8: atan_q16 = 32'sd14668;
         5'd9: atan_q16 = 32'sd7334;
         5'd10: atan_q16 = 32'sd3667;
         5'd11: atan_q16 = 32'sd1833;
         5'd12: atan_q16 = 32'sd917;
         5'd13: atan_q16 = 32'sd458;
         5'd14: atan_q16 = 32'sd229;
         5'd15: atan_q16 = 32'sd115;
         5'd16: atan_q16 = 32'sd57;
         5'd17: atan_q16 = 32'sd29;
         5'd18: atan_q16 = 32'sd14;
         5'd19: atan_q16 = 32'sd7;
         5'd20: atan_q16 = 32'sd4;
         5'd21: atan_q16 = 32'sd2;
         5'd22: atan_q16 = 32'sd1;
         default: atan_q16 = 32'sd0;
      endcase
   endfunction

endpackage

@@ rtl/imu_tilt_and_motion_classifier.sv @@
// Top level of the IMU tilt and motion classifier: registers, sequencer, datapath.
// Depends on imutc_pkg, imutc_ctrl and imutc_dp.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_stall  | req_word (req_word_type)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_word (rsp_word_type)
//   csr     | in        | csr_write            | csr_index, csr_data
//
// A new word is accepted only once the previous word's sequence has run to its
// end; the shared CORDIC stage sets most of that time, and the gyro increment
// adds four multiply steps per axis.
// Reset clears the windows, angle stores, motion code and warm-up timer at once.
// A finished result waits in the output register while the block is idle,
// and a new word is taken while that result is still stalled; that word's own
// result then waits in the last sequencer state until the output is free.
module imu_tilt_and_motion_classifier
   import imutc_pkg::*;
#(
   parameter int WINDOW_LEN = WindowLenDefault,
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_word_type            req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_word_type            rsp_word,
   input  logic                    csr_write,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   logic [15:0] blend_ff;
   logic [23:0] warmup_ff;
   logic [14:0] still_ff, turn_ff, spin_ff, accel_ff;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers; writes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff <= 16'd63570;
         warmup_ff <= 24'd3000000;
         still_ff <= 15'd524;
         turn_ff <= 15'd655;
         spin_ff <= 15'd19650;
         accel_ff <= 15'd3277;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BLEND: blend_ff <= csr_data[15:0];
            CSR_WARMUP: warmup_ff <= csr_data;
            CSR_STILL: still_ff <= csr_data[14:0];
            CSR_TURN: turn_ff <= csr_data[14:0];
            CSR_SPIN: spin_ff <= csr_data[14:0];
            CSR_ACCEL: accel_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   imutc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid), .sts(sts), .req_stall(req_stall), .cmd(cmd)
   );

   imutc_dp #(.WINDOW_LEN(WINDOW_LEN), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_word(req_word),
      .blend_weight(blend_ff), .warmup_time(warmup_ff), .still_rate_limit(still_ff),
      .turn_rate_limit(turn_ff), .spin_rate_limit(spin_ff), .accel_limit(accel_ff),
      .rsp_stall(rsp_stall), .sts(sts), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   // Motion codes never leave the defined set.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.motion_code <= MOTION_AROUND)
      else $error("motion code out of range");

   // An accepted word always leads into work, never back to idle at once.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accept did not start work");

   // A result appears only on completion of the sequence.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result without finished sequence");

endmodule

@@ rtl/imutc_ctrl.sv @@
// Sequencer for the tilt and motion block.
// Depends on imutc_pkg.
module imutc_ctrl
   import imutc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    rsp_stall,
   input  logic    rsp_valid,
   input  sts_type sts,
   output logic    req_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      // A new word may enter while the previous result still waits.
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            cmd.mag_step = 1'b1;
            if (sts.step_last) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in = ST_ANG;
         end
         ST_ANG: begin
            cmd.ang_step = 1'b1;
            if (sts.step_last) state_in = ST_GYRO;
         end
         ST_GYRO: begin
            cmd.gyro = 1'b1;
            if (sts.div_last) state_in = ST_BLEND;
         end
         ST_BLEND: begin
            cmd.blend = 1'b1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (sts.axis_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.next_axis = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ rtl/imutc_dp.sv @@
// Datapath: warm-up timer, averaging windows, shared CORDIC, gyro increment,
// blend and motion classification. Depends on imutc_pkg.
module imutc_dp
   import imutc_pkg::*;
#(
   parameter int WINDOW_LEN = WindowLenDefault,
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  req_word_type req_word,
   input  logic [15:0]  blend_weight,
   input  logic [23:0]  warmup_time,
   input  logic [14:0]  still_rate_limit,
   input  logic [14:0]  turn_rate_limit,
   input  logic [14:0]  spin_rate_limit,
   input  logic [14:0]  accel_limit,
   input  logic         rsp_stall,
   output sts_type      sts,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int SlotW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SumW = 16 + $clog2(WINDOW_LEN + 1);
   localparam int CW = 56;  // CORDIC datapath width
   localparam int StepW = $clog2(CORDIC_STEPS);
   localparam logic [StepW-1:0] StepLast = StepW'(CORDIC_STEPS - 1);

   // Gyro increment constants. Numerator and divisor are both divided by 64 first,
   // which leaves an exact floor division by 2046875 of a value below 2^46. That
   // division is a multiply by a 47-bit reciprocal followed by a shift by 67.
   localparam logic [127:0] GyroDivRed = 128'(GYRO_DIV >> 6);
   localparam logic [127:0] RecipWide = ((128'd1 << 67) + GyroDivRed - 128'd1) / GyroDivRed;
   localparam logic [46:0] Recip = RecipWide[46:0];
   localparam logic [45:0] GyroBias = 46'((GYRO_DIV >> 1) >> 6);

   logic signed [15:0] winx_ff [WINDOW_LEN];
   logic signed [15:0] winy_ff [WINDOW_LEN];
   logic signed [15:0] winz_ff [WINDOW_LEN];
   logic [SlotW-1:0] slot_ff;
   logic [23:0] elapsed_ff;
   logic enabled_ff;
   logic signed [31:0] roll_ff, pitch_ff, yaw_ff;
   logic [2:0] motion_ff;
   logic signed [15:0] gx_ff, gy_ff, gz_ff;
   logic [19:0] dt_ff;
   logic signed [SumW-1:0] sx_ff, sy_ff, sz_ff;
   logic [1:0] axis_ff;
   logic signed [CW-1:0] cx_ff, cy_ff, num_ff;
   logic signed [31:0] cz_ff;
   logic [StepW-1:0] step_ff;
   logic [45:0] dnum_ff;
   logic [92:0] acc_ff;
   logic [1:0] dcnt_ff;
   logic dneg_ff;
   logic rsp_valid_ff;
   rsp_word_type rsp_ff;

   // Window update values.
   logic [24:0] t_sum;
   logic [23:0] elapsed_new;
   logic en_new;
   logic signed [15:0] ax_new, ay_new, az_new;
   logic signed [SumW-1:0] sx_new, sy_new, sz_new;

   always_comb begin
      t_sum = {1'b0, elapsed_ff} + 25'(req_word.delta_time);
      elapsed_new = t_sum[24] ? 24'hFFFFFF : t_sum[23:0];
      en_new = enabled_ff || (elapsed_new > warmup_time);
      ax_new = en_new ? req_word.accel_x : 16'sd0;
      ay_new = en_new ? req_word.accel_y : 16'sd0;
      az_new = en_new ? req_word.accel_z : 16'sd0;
      sx_new = SumW'(ax_new);
      sy_new = SumW'(ay_new);
      sz_new = SumW'(az_new);
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (SlotW'(i) != slot_ff) begin
            sx_new = sx_new + SumW'(winx_ff[i]);
            sy_new = sy_new + SumW'(winy_ff[i]);
            sz_new = sz_new + SumW'(winz_ff[i]);
         end
      end
   end

   // Axis selection: roll (axis 0) uses num=Y,(a,b)=(X,Z); pitch uses num=-X,(a,b)=(Y,Z).
   logic signed [CW-1:0] sel_a, sel_b, sel_num, abs_a;
   always_comb begin
      if (axis_ff == 2'd0) begin
         sel_a = CW'(sx_ff) <<< 12;
         sel_num = CW'(sy_ff) <<< 12;
      end else begin
         sel_a = CW'(sy_ff) <<< 12;
         sel_num = -(CW'(sx_ff) <<< 12);
      end
      sel_b = CW'(sz_ff) <<< 12;
      abs_a = sel_a[CW-1] ? -sel_a : sel_a;
   end

   // One CORDIC vectoring step.
   logic signed [CW-1:0] dx, dy, nx, ny;
   logic signed [31:0] nz, atan_v;
   always_comb begin
      dx = cy_ff >>> step_ff;
      dy = cx_ff >>> step_ff;
      atan_v = atan_q16(5'(step_ff));
      if (!cy_ff[CW-1]) begin
         nx = cx_ff + dx; ny = cy_ff - dy; nz = cz_ff + atan_v;
      end else begin
         nx = cx_ff - dx; ny = cy_ff + dy; nz = cz_ff - atan_v;
      end
   end

   // Magnitude scale: xm is below 2^51, split into two 26-bit halves.
   logic [25:0] xm_lo, xm_hi;
   logic [57:0] p_lo, p_hi;
   logic [CW-1:0] m_val;
   logic [83:0] prod;
   always_comb begin
      xm_lo = cx_ff[25:0];
      xm_hi = cx_ff[51:26];
      p_lo = 58'(xm_lo) * 58'(INV_GAIN_Q30);
      p_hi = 58'(xm_hi) * 58'(INV_GAIN_Q30);
      prod = 84'(p_lo) + (84'(p_hi) << 26) + (84'd1 << 29);
      m_val = CW'(prod[83:30]);
   end

   // Gyro increment: the reciprocal product is built from four partial products,
   // one per cycle, low half of the dividend first.
   logic signed [15:0] g_sel;
   logic signed [36:0] g_prod;
   logic [35:0] g_mag;
   logic [22:0] pp_a;
   logic [23:0] pp_b;
   logic [46:0] pp;
   logic [92:0] pp_shift;
   logic [25:0] quo;
   always_comb begin
      case (axis_ff)
         2'd0: g_sel = gx_ff;
         2'd1: g_sel = gy_ff;
         default: g_sel = gz_ff;
      endcase
      g_prod = 37'(g_sel) * $signed({17'd0, dt_ff});
      g_mag = g_prod[36] ? 36'(-g_prod) : 36'(g_prod);
      pp_a = dcnt_ff[1] ? dnum_ff[45:23] : dnum_ff[22:0];
      pp_b = dcnt_ff[0] ? {1'b0, Recip[46:24]} : Recip[23:0];
      pp = 47'(pp_a) * 47'(pp_b);
      case (dcnt_ff)
         2'd0: pp_shift = 93'(pp);
         2'd1: pp_shift = 93'(pp) << 24;
         2'd2: pp_shift = 93'(pp) << 23;
         default: pp_shift = 93'(pp) << 47;
      endcase
      quo = acc_ff[92:67];
   end

   // Blend: partial products kept within one multiplier width each.
   logic signed [33:0] gyro_ang, acc_ang;
   logic signed [26:0] incr;
   logic signed [31:0] prev_ang;
   logic signed [51:0] bl_sum;
   logic signed [35:0] bl_r;
   logic signed [31:0] bl_sat;
   always_comb begin
      incr = dneg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      prev_ang = (axis_ff == 2'd0) ? roll_ff : pitch_ff;
      gyro_ang = 34'(prev_ang) + 34'(incr);
      acc_ang = 34'(cz_ff);
      bl_sum = 52'(gyro_ang) * $signed({36'd0, blend_weight})
             + 52'(acc_ang) * $signed(52'(17'h10000 - 17'(blend_weight)))
             + 52'sd32768;
      bl_r = 36'(bl_sum >>> 16);
      if (bl_r > 36'sd2147483647) bl_sat = 32'h7FFFFFFF;
      else if (bl_r < -36'sd2147483648) bl_sat = 32'h80000000;
      else bl_sat = bl_r[31:0];
   end

   // Motion classification.
   logic [15:0] gz_abs;
   logic signed [SumW+15:0] lim;
   logic [2:0] motion_new;
   always_comb begin
      gz_abs = gz_ff[15] ? 16'(-gz_ff) : 16'(gz_ff);
      lim = (SumW+16)'(accel_limit) * (SumW+16)'(WINDOW_LEN);
      motion_new = motion_ff;
      if (gz_abs < {1'b0, still_rate_limit}) begin
         if ((SumW+16)'(sy_ff) > lim) motion_new = MOTION_ACCEL;
         else if ((SumW+16)'(sy_ff) < -lim) motion_new = MOTION_DECEL;
         else motion_new = MOTION_CONST;
      end else if (gz_abs > {1'b0, spin_rate_limit}) begin
         motion_new = MOTION_AROUND;
      end else if (gz_ff > $signed({1'b0, turn_rate_limit})) begin
         motion_new = MOTION_RIGHT;
      end else if (gz_ff < -$signed({1'b0, turn_rate_limit})) begin
         motion_new = MOTION_LEFT;
      end
   end

   logic zero_vec;
   assign zero_vec = (cx_ff == '0) && (num_ff == '0);

   assign sts.step_last = (step_ff == StepLast);
   assign sts.div_last = (dcnt_ff == 2'd3);
   assign sts.axis_last = (axis_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            winx_ff[i] <= '0; winy_ff[i] <= '0; winz_ff[i] <= '0;
         end
         slot_ff <= '0;
         elapsed_ff <= '0;
         enabled_ff <= 1'b0;
         roll_ff <= '0; pitch_ff <= '0; yaw_ff <= '0;
         motion_ff <= MOTION_HALT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            elapsed_ff <= elapsed_new;
            enabled_ff <= en_new;
            winx_ff[slot_ff] <= ax_new;
            winy_ff[slot_ff] <= ay_new;
            winz_ff[slot_ff] <= az_new;
            slot_ff <= (slot_ff == SlotW'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
         end
         if (cmd.blend) begin
            case (axis_ff)
               2'd0: roll_ff <= bl_sat;
               2'd1: pitch_ff <= bl_sat;
               default: yaw_ff <= yaw_ff + 32'(incr);
            endcase
         end
         if (cmd.finish) begin
            motion_ff <= motion_new;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         gx_ff <= req_word.gyro_x; gy_ff <= req_word.gyro_y; gz_ff <= req_word.gyro_z;
         dt_ff <= req_word.delta_time;
         sx_ff <= sx_new; sy_ff <= sy_new; sz_ff <= sz_new;
         axis_ff <= 2'd0;
      end
      if (cmd.next_axis) axis_ff <= axis_ff + 2'd1;
      if (cmd.prep) begin
         cx_ff <= abs_a; cy_ff <= sel_b; cz_ff <= '0;
         num_ff <= sel_num;
         step_ff <= '0;
         dcnt_ff <= '0;
         acc_ff <= '0;
         // Half the divisor, scaled down by 64, rounds the quotient half up.
         dnum_ff <= {g_mag, 10'd0} + GyroBias;
         dneg_ff <= g_prod[36];
      end
      if (cmd.mag_step || cmd.ang_step) begin
         cx_ff <= nx; cy_ff <= ny;
         // A zero vector has no direction, so its angle reads as zero.
         cz_ff <= (cmd.ang_step && sts.step_last && zero_vec) ? '0 : nz;
         step_ff <= sts.step_last ? '0 : step_ff + 1'b1;
      end
      if (cmd.scale) begin
         cx_ff <= m_val; cy_ff <= num_ff; cz_ff <= '0;
      end
      if (cmd.gyro) begin
         acc_ff <= acc_ff + pp_shift;
         dcnt_ff <= dcnt_ff + 2'd1;
      end
      if (cmd.finish) begin
         rsp_ff.roll_angle <= roll_ff;
         rsp_ff.pitch_angle <= pitch_ff;
         rsp_ff.yaw_angle <= yaw_ff;
         rsp_ff.motion_code <= motion_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule
